/* hdl/u8dec_pkg.sv */
// Shared types and constants for the UTF-8 codepoint decoder.
package u8dec_pkg;

    localparam int CP_W = 21;

    typedef logic [CP_W-1:0] cp_t;

    localparam cp_t CP_REPLACEMENT = 21'h00FFFD;
    localparam cp_t CP_MAX         = 21'h10FFFF;
    localparam cp_t CP_SURR_LO     = 21'h00D800;
    localparam cp_t CP_SURR_HI     = 21'h00DFFF;
    localparam cp_t CP_MIN_LEN2    = 21'h000080;
    localparam cp_t CP_MIN_LEN3    = 21'h000800;
    localparam cp_t CP_MIN_LEN4    = 21'h010000;
    localparam cp_t CP_BOM         = 21'h00FEFF;

    typedef logic [2:0] seq_len_t;
    localparam seq_len_t SEQ_LEN_NONE = 3'd0;
    localparam seq_len_t SEQ_LEN_2    = 3'd2;
    localparam seq_len_t SEQ_LEN_3    = 3'd3;
    localparam seq_len_t SEQ_LEN_4    = 3'd4;

    // One input beat as held in the input register.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       label_last;
    } dec_beat_t;

    // One result beat.
    typedef struct packed {
        cp_t  codepoint;
        logic has_codepoint;
        logic replaced;
        logic label_done;
    } dec_result_t;

endpackage

/* hdl/utf8_codepoint_decoder_top.sv */
// Top level of the UTF-8 codepoint decoder.
//
// Input channel (in_valid/in_ready): one byte of a label per beat on data_byte,
// with label_last high on the label's final byte.
// Output channel (out_valid/out_ready): at most one result beat per input byte:
// a codepoint (U+FFFD with replaced set for overlong, surrogate or out-of-range
// sequences) and/or label_done on the label's last byte. Bytes that complete no
// codepoint and are not a label's last byte give no result beat.
// cfg_we/cfg_wdata write skip_bom (reset 1), which drops a byte order mark
// EF BB BF at the start of a label. Write it only while the block is idle.
// A byte accepted into the input register is decoded, and its result, if any, is
// loaded into the output register, from which it is offered. One byte per cycle
// unless a result waits on a stalled receiver, set by the single decode step between the two registers.
// A stalled receiver holds the output register; the input register still takes
// one more byte, and bytes that give no result keep flowing past the stall.
// Reset empties both registers and leaves the decoder at a label start.
module utf8_codepoint_decoder_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 label_last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output u8dec_pkg::cp_t       codepoint,
    output logic                 has_codepoint,
    output logic                 replaced,
    output logic                 label_done,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata
);
    import u8dec_pkg::*;

    dec_beat_t   in_beat;
    dec_beat_t   beat;
    logic        beat_valid;
    logic        step;
    logic        emit;
    logic        space;
    dec_result_t res;
    dec_result_t out_res;
    logic        skip_bom_reg;

    assign in_beat.data_byte  = data_byte;
    assign in_beat.label_last = label_last;

    // A beat that yields no result moves on even when the output is full.
    assign step = beat_valid && (!emit || space);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_bom_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            skip_bom_reg <= cfg_wdata;
        end
    end

    u8dec_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_beat    (in_beat),
        .take       (step),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    u8dec_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .beat     (beat),
        .skip_bom (skip_bom_reg),
        .emit     (emit),
        .res      (res)
    );

    u8dec_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && emit),
        .res       (res),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign codepoint     = out_res.codepoint;
    assign has_codepoint = out_res.has_codepoint;
    assign replaced      = out_res.replaced;
    assign label_done    = out_res.label_done;

    // Every result beat carries something.
    a_beat_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> has_codepoint || label_done)
        else $error("empty result beat");

    // Without a codepoint the value and replaced flag are zero.
    a_no_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_codepoint |-> (codepoint == '0) && !replaced)
        else $error("stale codepoint fields on result beat");

    // A codepoint that is not replaced is a Unicode scalar value.
    a_scalar_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_codepoint && !replaced
            |-> (codepoint <= CP_MAX)
                && ((codepoint < CP_SURR_LO) || (codepoint > CP_SURR_HI)))
        else $error("non-scalar codepoint emitted");

endmodule

/* hdl/u8dec_in_stage.sv */
// Input register stage: holds one accepted byte beat until the decoder consumes it.
module u8dec_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  u8dec_pkg::dec_beat_t in_beat,
    input  logic                 take,
    output logic                 beat_valid,
    output u8dec_pkg::dec_beat_t beat
);
    import u8dec_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    dec_beat_t beat_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg <= in_beat;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

/* hdl/u8dec_core.sv */
// Decode step: sequence state registers and the per-byte decode logic.
module u8dec_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  u8dec_pkg::dec_beat_t   beat,
    input  logic                   skip_bom,
    output logic                   emit,
    output u8dec_pkg::dec_result_t res
);
    import u8dec_pkg::*;

    cp_t      accum_reg, accum_next;
    logic [1:0] rem_reg, rem_next;
    seq_len_t seq_len_reg, seq_len_next;
    logic     at_start_reg, at_start_next;
    logic     from_start_reg, from_start_next;

    cp_t  shifted;
    logic bad;
    logic is_cont;

    assign shifted = {accum_reg[CP_W-7:0], beat.data_byte[5:0]};
    assign is_cont = (rem_reg != 2'd0) && (beat.data_byte[7:6] == 2'b10);

    always_comb
    begin
        accum_next      = accum_reg;
        rem_next        = rem_reg;
        seq_len_next    = seq_len_reg;
        at_start_next   = 1'b0;
        from_start_next = from_start_reg;
        res             = '0;
        bad             = 1'b0;

        if (is_cont)
        begin
            accum_next = shifted;
            rem_next   = rem_reg - 2'd1;
            if (rem_reg == 2'd1)
            begin
                case (seq_len_reg)
                    SEQ_LEN_2: bad = shifted < CP_MIN_LEN2;
                    SEQ_LEN_3: bad = (shifted < CP_MIN_LEN3)
                                     || (shifted inside {[CP_SURR_LO:CP_SURR_HI]});
                    default:   bad = (shifted < CP_MIN_LEN4) || (shifted > CP_MAX);
                endcase
                if (bad)
                begin
                    res.has_codepoint = 1'b1;
                    res.replaced      = 1'b1;
                    res.codepoint     = CP_REPLACEMENT;
                end
                else if (!((seq_len_reg == SEQ_LEN_3) && from_start_reg && skip_bom
                           && (shifted == CP_BOM)))
                begin
                    res.has_codepoint = 1'b1;
                    res.codepoint     = shifted;
                end
            end
        end
        else
        begin
            // Any non-continuation byte drops a pending sequence and starts afresh.
            rem_next = 2'd0;
            if (!beat.data_byte[7])
            begin
                res.has_codepoint = 1'b1;
                res.codepoint     = {{(CP_W-8){1'b0}}, beat.data_byte};
            end
            else if (beat.data_byte[7:5] == 3'b110)
            begin
                accum_next      = {{(CP_W-5){1'b0}}, beat.data_byte[4:0]};
                rem_next        = 2'd1;
                seq_len_next    = SEQ_LEN_2;
                from_start_next = at_start_reg;
            end
            else if (beat.data_byte[7:4] == 4'b1110)
            begin
                accum_next      = {{(CP_W-4){1'b0}}, beat.data_byte[3:0]};
                rem_next        = 2'd2;
                seq_len_next    = SEQ_LEN_3;
                from_start_next = at_start_reg;
            end
            else if (beat.data_byte[7:3] == 5'b11110)
            begin
                accum_next      = {{(CP_W-3){1'b0}}, beat.data_byte[2:0]};
                rem_next        = 2'd3;
                seq_len_next    = SEQ_LEN_4;
                from_start_next = at_start_reg;
            end
        end

        if (beat.label_last)
        begin
            accum_next      = '0;
            rem_next        = 2'd0;
            seq_len_next    = SEQ_LEN_NONE;
            from_start_next = 1'b0;
            at_start_next   = 1'b1;
        end

        res.label_done = beat.label_last;
        emit           = res.has_codepoint || beat.label_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg      <= '0;
            rem_reg        <= 2'd0;
            seq_len_reg    <= SEQ_LEN_NONE;
            at_start_reg   <= 1'b1;
            from_start_reg <= 1'b0;
        end
        else if (step)
        begin
            accum_reg      <= accum_next;
            rem_reg        <= rem_next;
            seq_len_reg    <= seq_len_next;
            at_start_reg   <= at_start_next;
            from_start_reg <= from_start_next;
        end
    end

    // Label end always leaves the decoder idle at a label start.
    a_label_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && beat.label_last |=> at_start_reg && (rem_reg == 2'd0))
        else $error("decoder state not cleared at label end");

    // A pending sequence always has a length that covers the bytes still due.
    a_len_covers_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg != 2'd0) |-> (seq_len_reg > {1'b0, rem_reg})
                              && (seq_len_reg <= SEQ_LEN_4))
        else $error("sequence length inconsistent with remaining count");

    // An ASCII byte always decodes to itself.
    a_ascii_passes: assert property (@(posedge clk) disable iff (!rst_n)
        step && !beat.data_byte[7] |-> emit && res.has_codepoint
                                       && (res.codepoint[7:0] == beat.data_byte))
        else $error("ASCII byte not passed through");

endmodule

/* hdl/u8dec_out_stage.sv */
// Output register stage: holds one result beat until the receiver takes it.
module u8dec_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  u8dec_pkg::dec_result_t res,
    output logic                   space,
    output logic                   out_valid,
    input  logic                   out_ready,
    output u8dec_pkg::dec_result_t out_res
);
    import u8dec_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    dec_result_t res_reg;

    assign space      = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

/* dv/utf8_codepoint_decoder_top_tb.sv */
// Self-checking testbench for the UTF-8 codepoint decoder top level.
`timescale 1ns / 100ps

module utf8_codepoint_decoder_top_tb;

    import u8dec_pkg::*;

    localparam int BYTES_PER_PHASE = 370;
    localparam int NUM_PHASES      = 5;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte   = 8'h00;
    logic       label_last  = 1'b0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    cp_t        codepoint;
    logic       has_codepoint;
    logic       replaced;
    logic       label_done;
    logic       cfg_we      = 1'b0;
    logic       cfg_wdata   = 1'b0;

    // Bytes waiting to be sent, and decoded results waiting to be seen.
    dec_beat_t   byte_queue [$];
    dec_result_t expected_results [$];
    logic [7:0]  label_bytes [$];

    // Decoder state as predicted by the testbench.
    cp_t        acc_bits;
    logic [1:0] cont_left;
    seq_len_t   seq_len;
    logic       at_start;
    logic       from_start;
    logic       bom_skip;

    int send_odds;
    int stall_odds;
    int send_gap;
    int stall_gap;
    int mismatches;

    utf8_codepoint_decoder_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .label_last    (label_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .codepoint     (codepoint),
        .has_codepoint (has_codepoint),
        .replaced      (replaced),
        .label_done    (label_done),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #1 clk = ~clk;

    function automatic void append_byte(input logic [7:0] b);
        label_bytes.insert(label_bytes.size(), b);
    endfunction

    function automatic void queue_beat(input dec_beat_t beat);
        byte_queue.insert(byte_queue.size(), beat);
    endfunction

    function automatic void queue_result(input dec_result_t res);
        expected_results.insert(expected_results.size(), res);
    endfunction

    // Advance the decoder state by one byte and queue the result it causes.
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        dec_result_t res;
        logic        emit;
        logic        bad;
        res  = '0;
        emit = 1'b0;
        bad  = 1'b0;
        if (cont_left != 2'd0 && b[7:6] == 2'b10)
        begin
            acc_bits  = {acc_bits[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0)
            begin
                case (seq_len)
                    SEQ_LEN_2: bad = acc_bits < CP_MIN_LEN2;
                    SEQ_LEN_3: bad = acc_bits < CP_MIN_LEN3
                                     || (acc_bits >= CP_SURR_LO && acc_bits <= CP_SURR_HI);
                    default:   bad = acc_bits < CP_MIN_LEN4 || acc_bits > CP_MAX;
                endcase
                if (bad)
                begin
                    res.codepoint = CP_REPLACEMENT;
                    res.replaced  = 1'b1;
                    emit          = 1'b1;
                end
                else if (!(seq_len == SEQ_LEN_3 && from_start && bom_skip
                           && acc_bits == CP_BOM))
                begin
                    res.codepoint = acc_bits;
                    emit          = 1'b1;
                end
            end
        end
        else
        begin
            cont_left = 2'd0;
            if (!b[7])
            begin
                res.codepoint = cp_t'(b);
                emit          = 1'b1;
            end
            else if (b[7:5] == 3'b110)
            begin
                acc_bits   = cp_t'(b[4:0]);
                cont_left  = 2'd1;
                seq_len    = SEQ_LEN_2;
                from_start = at_start;
            end
            else if (b[7:4] == 4'b1110)
            begin
                acc_bits   = cp_t'(b[3:0]);
                cont_left  = 2'd2;
                seq_len    = SEQ_LEN_3;
                from_start = at_start;
            end
            else if (b[7:3] == 5'b11110)
            begin
                acc_bits   = cp_t'(b[2:0]);
                cont_left  = 2'd3;
                seq_len    = SEQ_LEN_4;
                from_start = at_start;
            end
            // stray continuations and F8-FF fall through: dropped
        end
        at_start = 1'b0;
        if (last)
        begin
            acc_bits   = '0;
            cont_left  = 2'd0;
            seq_len    = SEQ_LEN_NONE;
            from_start = 1'b0;
            at_start   = 1'b1;
        end
        res.has_codepoint = emit;
        res.label_done    = last;
        if (emit || last)
            queue_result(res);
    endfunction

    function automatic void check_field(input string name, input cp_t want, input cp_t got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Encode v as a len-byte sequence; overlong and out-of-range values pass through.
    function automatic void put_seq(input cp_t v, input int len);
        case (len)
            2:
            begin
                append_byte({3'b110, v[10:6]});
                append_byte({2'b10, v[5:0]});
            end
            3:
            begin
                append_byte({4'b1110, v[15:12]});
                append_byte({2'b10, v[11:6]});
                append_byte({2'b10, v[5:0]});
            end
            default:
            begin
                append_byte({5'b11110, v[20:18]});
                append_byte({2'b10, v[17:12]});
                append_byte({2'b10, v[11:6]});
                append_byte({2'b10, v[5:0]});
            end
        endcase
    endfunction

    function automatic cp_t legal_cp(input int len);
        cp_t v;
        case (len)
            2: v = cp_t'($urandom_range(21'h80, 21'h7FF));
            3:
            begin
                v = cp_t'($urandom_range(21'h800, 21'hFFFF));
                if (v >= CP_SURR_LO && v <= CP_SURR_HI)
                    v = v ^ 21'h002000;
            end
            default: v = cp_t'($urandom_range(21'h10000, 21'h10FFFF));
        endcase
        return v;
    endfunction

    function automatic void add_char();
        int         kind;
        int         len;
        int         drop;
        cp_t        v;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 25)
        begin
            b = 8'($urandom_range(0, 8'h7F));
            append_byte(b);
        end
        else if (kind < 67)
        begin
            len = (kind < 40) ? 2 : (kind < 55) ? 3 : 4;
            put_seq(legal_cp(len), len);
        end
        else if (kind < 71)
        begin
            // overlong form
            len = $urandom_range(2, 4);
            case (len)
                2:       v = cp_t'($urandom_range(0, 21'h7F));
                3:       v = cp_t'($urandom_range(0, 21'h7FF));
                default: v = cp_t'($urandom_range(0, 21'hFFFF));
            endcase
            put_seq(v, len);
        end
        else if (kind < 74)
            put_seq(cp_t'($urandom_range(CP_SURR_LO, CP_SURR_HI)), 3);
        else if (kind < 77)
            put_seq(cp_t'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
        else if (kind < 80)
            put_seq(CP_BOM, 3);
        else if (kind < 88)
        begin
            // truncated sequence, broken by whatever follows
            len = $urandom_range(2, 4);
            put_seq(legal_cp(len), len);
            drop = $urandom_range(1, len - 1);
            repeat (drop) b = label_bytes.pop_back();
        end
        else if (kind < 94)
        begin
            b = 8'($urandom_range(8'h80, 8'hBF));
            append_byte(b);
        end
        else if (kind < 97)
        begin
            b = 8'($urandom_range(8'hF8, 8'hFF));
            append_byte(b);
        end
        else
        begin
            b = 8'($urandom_range(0, 8'hFF));
            append_byte(b);
        end
    endfunction

    function automatic int add_label();
        dec_beat_t beat;
        int        n;
        label_bytes.delete();
        if ($urandom_range(0, 3) == 0)
            put_seq(CP_BOM, 3);
        n = $urandom_range(1, 6);
        repeat (n) add_char();
        foreach (label_bytes[i])
        begin
            beat.data_byte  = label_bytes[i];
            beat.label_last = (i == label_bytes.size() - 1);
            queue_beat(beat);
        end
        return label_bytes.size();
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (byte_queue.size() != 0 || in_valid || expected_results.size() != 0);
        // bytes that give no result may still sit in the input register
        repeat (4) @(posedge clk);
    endtask

    task automatic write_skip_bom(input logic value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        bom_skip   = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Driver: one beat per handshake, with random gaps.
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        dec_beat_t beat;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            data_byte  <= 8'h00;
            label_last <= 1'b0;
            send_gap    = 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (send_odds != 0 && $urandom_range(1, send_odds) == 1)
            begin
                send_gap  = $urandom_range(0, 15);
                in_valid <= 1'b0;
            end
            else if (byte_queue.size() != 0)
            begin
                beat        = byte_queue.pop_front();
                in_valid   <= 1'b1;
                data_byte  <= beat.data_byte;
                label_last <= beat.label_last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: predicts on accepted input beats, checks accepted result beats.
    always @(posedge clk or negedge rst_n)
    begin : check_proc
        dec_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_gap  = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                decode_byte(data_byte, label_last);
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result beat: codepoint %0h label_done %0b",
                           codepoint, label_done);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("codepoint", want.codepoint, codepoint);
                    check_field("has_codepoint", cp_t'(want.has_codepoint),
                                cp_t'(has_codepoint));
                    check_field("replaced", cp_t'(want.replaced), cp_t'(replaced));
                    check_field("label_done", cp_t'(want.label_done), cp_t'(label_done));
                end
            end
            if (stall_gap > 0)
            begin
                stall_gap--;
                out_ready <= 1'b0;
            end
            else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                stall_gap  = $urandom_range(0, 15);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : stim_proc
        logic [8:0] directed_beats [];
        dec_beat_t  beat;
        int         queued;
        int         send_plan [NUM_PHASES];
        int         stall_plan [NUM_PHASES];
        acc_bits   = '0;
        cont_left  = 2'd0;
        seq_len    = SEQ_LEN_NONE;
        at_start   = 1'b1;
        from_start = 1'b0;
        bom_skip   = 1'b1;
        mismatches = 0;
        send_plan  = '{4, 8, 2, 16, 0};
        stall_plan = '{6, 2, 12, 3, 0};
        send_odds  = send_plan[0];
        stall_odds = stall_plan[0];

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // bit 8 marks the label's last byte
        directed_beats = '{
            // BOM at label start, then ASCII extremes
            9'h0EF, 9'h0BB, 9'h0BF, 9'h000, 9'h17F,
            // overlong pair, max 2-byte, surrogate, BOM mid-label
            9'h0C0, 9'h080, 9'h0DF, 9'h0BF, 9'h0ED, 9'h0A0, 9'h080,
            9'h0EF, 9'h0BB, 9'h0BF,
            // max scalar, F5 lead above range, lone continuation, bad lead
            9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, 9'h0F5, 9'h080, 9'h080, 9'h080,
            9'h080, 9'h0FF,
            // sequence broken by ASCII, then one cut by the label end
            9'h0C2, 9'h041, 9'h0E2, 9'h182
        };
        foreach (directed_beats[i])
        begin
            beat.data_byte  = directed_beats[i][7:0];
            beat.label_last = directed_beats[i][8];
            queue_beat(beat);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph != 0)
            begin
                wait_drained();
                write_skip_bom(ph % 2 == 0);
                send_odds  = send_plan[ph];
                stall_odds = stall_plan[ph];
            end
            queued = 0;
            while (queued < BYTES_PER_PHASE)
                queued += add_label();
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin : watchdog_proc
        #1000000;
        $display("status: fail");
        $finish;
    end

endmodule

/* utf8_codepoint_decoder_top.f */
hdl/u8dec_pkg.sv
hdl/u8dec_in_stage.sv
hdl/u8dec_core.sv
hdl/u8dec_out_stage.sv
hdl/utf8_codepoint_decoder_top.sv
dv/utf8_codepoint_decoder_top_tb.sv
